@@ hdl/scb_pkg.sv @@
// Package for the source comment blanker: byte codes, mode codes and the
// record types shared by the step logic, the result buffer and the top level.
// No dependencies.
package scb_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] MODE_CODE  = 2'd0;
    localparam logic [1:0] MODE_LINE  = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;
    localparam logic [1:0] MODE_LIT   = 2'd3;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       text_end;
    } t_res;

    typedef struct packed {
        logic [1:0] mode;
        logic       held;
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_step;

endpackage

@@ hdl/scb_step.sv @@
// Combinational step of the comment blanker: next mode, hold flag and up to
// two result bytes for one source byte.
// Depends on scb_pkg.
module scb_step
    import scb_pkg::*;
(
    input  logic [1:0] i_mode,
    input  logic       i_held,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_step      o_step
);

    logic [1:0] m;
    logic       h;
    logic       paired;
    logic [1:0] cnt;
    logic [7:0] e0;
    logic [7:0] e1;
    logic       is_quote;
    logic       f_emit;
    logic [7:0] f_char;

    assign is_quote = (i_char == CH_DQUOTE) || (i_char == CH_SQUOTE);

    always_comb begin
        m      = i_mode;
        h      = i_held;
        paired = 1'b0;
        cnt    = 2'd0;
        e0     = CH_SPACE;
        e1     = CH_SPACE;
        f_emit = 1'b0;
        f_char = CH_SPACE;

        if (h) begin
            if (m == MODE_CODE && (i_char == CH_SLASH || i_char == CH_STAR)) begin
                paired = 1'b1;
                m      = (i_char == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            end else if (m == MODE_BLOCK && i_char == CH_SLASH) begin
                paired = 1'b1;
                m      = MODE_CODE;
            end else if (m == MODE_LIT && is_quote) begin
                paired = 1'b1;
            end
            if (paired) begin
                cnt = 2'd2;
            end else if (m == MODE_CODE) begin
                e0  = CH_SLASH;
                cnt = 2'd1;
            end else if (m != MODE_LINE) begin
                cnt = 2'd1;
            end
            h = 1'b0;
        end

        if (!paired) begin
            case (m)
                MODE_CODE: begin
                    if (i_char == CH_SLASH) begin
                        h = 1'b1;
                    end else if (is_quote) begin
                        f_emit = 1'b1;
                        m      = MODE_LIT;
                    end else begin
                        f_emit = 1'b1;
                        f_char = i_char;
                    end
                end
                MODE_LINE: begin
                    f_emit = 1'b1;
                    if (i_char == CH_NL) begin
                        f_char = CH_NL;
                        m      = MODE_CODE;
                    end
                end
                MODE_BLOCK: begin
                    if (i_char == CH_STAR) begin
                        h = 1'b1;
                    end else begin
                        f_emit = 1'b1;
                        f_char = (i_char == CH_NL) ? CH_NL : CH_SPACE;
                    end
                end
                default: begin
                    if (i_char == CH_BSLASH) begin
                        h = 1'b1;
                    end else if (is_quote) begin
                        f_emit = 1'b1;
                        m      = MODE_CODE;
                    end else if (i_char == CH_NL) begin
                        f_emit = 1'b1;
                        f_char = CH_NL;
                        m      = MODE_CODE;
                    end else begin
                        f_emit = 1'b1;
                    end
                end
            endcase
            if (f_emit) begin
                if (cnt == 2'd0) begin
                    e0 = f_char;
                end else begin
                    e1 = f_char;
                end
                cnt = cnt + 2'd1;
            end
        end

        if (i_last) begin
            if (h && m != MODE_LINE) begin
                if (cnt == 2'd0) begin
                    e0 = (m == MODE_CODE) ? CH_SLASH : CH_SPACE;
                end else begin
                    e1 = (m == MODE_CODE) ? CH_SLASH : CH_SPACE;
                end
                cnt = cnt + 2'd1;
            end
            m = MODE_CODE;
            h = 1'b0;
        end

        o_step.mode          = m;
        o_step.held          = h;
        o_step.cnt           = cnt;
        o_step.res0.out_char = e0;
        o_step.res0.run_last = (cnt == 2'd1);
        o_step.res0.text_end = (cnt == 2'd1) && i_last;
        o_step.res1.out_char = e1;
        o_step.res1.run_last = 1'b1;
        o_step.res1.text_end = i_last;
    end

endmodule

@@ hdl/scb_out_buf.sv @@
// Two-entry result buffer of the comment blanker: takes zero to two results
// per cycle and presents them one per transfer on the master side.
// Depends on scb_pkg.
module scb_out_buf
    import scb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_res       i_res0,
    input  t_res       i_res1,
    input  logic       i_tready,
    output logic       o_tvalid,
    output t_res       o_res,
    output logic [1:0] o_space
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_res       r_slot0;
    t_res       r_slot1;
    t_res       n_slot0;
    t_res       n_slot1;
    logic       pop;
    logic [1:0] kept_cnt;
    t_res       kept0;

    assign o_tvalid = (r_cnt != 2'd0);
    assign o_res    = r_slot0;
    assign o_space  = 2'd2 - kept_cnt;
    assign pop      = o_tvalid && i_tready;

    always_comb begin
        kept_cnt = r_cnt - {1'b0, pop};
        kept0    = pop ? r_slot1 : r_slot0;
        n_slot0  = (kept_cnt != 2'd0) ? kept0 : i_res0;
        case (kept_cnt)
            2'd0:    n_slot1 = i_res1;
            2'd1:    n_slot1 = i_res0;
            default: n_slot1 = r_slot1;
        endcase
        n_cnt = kept_cnt + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

@@ hdl/source_comment_blanker.sv @@
// Top level of the source comment blanker: input register, mode and hold
// state, step logic and result buffer.
// Depends on scb_pkg, scb_step and scb_out_buf.
//
//  channel  | dir | tdata          | tuser         | tlast
//  ---------+-----+----------------+---------------+---------
//  s_axis   | in  | [7:0] in_char  | -             | in_last
//  m_axis   | out | [7:0] out_char | [0] run_last  | text_end
//
// One source byte per cycle while the result buffer has room. A byte with
// two results waits in the input register until both fit in the two-entry
// result buffer. Synchronous active-low reset returns to code mode with no
// byte held. Stalls on the master side fill the buffer and then hold the
// input register; the slave side keeps taking bytes until then.
module source_comment_blanker
    import scb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [0:0] m_axis_tuser,   // [0] run_last
    output logic       m_axis_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic [1:0] r_mode;
    logic       r_held;
    t_step      step;
    logic [1:0] space;
    logic       fire;
    t_res       res;

    scb_step u_step (
        .i_mode (r_mode),
        .i_held (r_held),
        .i_char (r_in_char),
        .i_last (r_in_last),
        .o_step (step)
    );

    assign fire          = r_in_valid && (step.cnt <= space);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_CODE;
            r_held     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_mode <= step.mode;
                r_held <= step.held;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    scb_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? step.cnt : 2'd0),
        .i_res0     (step.res0),
        .i_res1     (step.res1),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_res      (res),
        .o_space    (space)
    );

    assign m_axis_tdata    = res.out_char;
    assign m_axis_tuser[0] = res.run_last;
    assign m_axis_tlast    = res.text_end;

endmodule
